// File: hw/rtl/dfpm_pkg.sv
package dfpm_pkg;

    localparam int MAX_FRAMES = 16;

    localparam logic [2:0] ST_FREE  = 3'd0;
    localparam logic [2:0] ST_ALLOC = 3'd1;
    localparam logic [2:0] ST_STBY  = 3'd2;
    localparam logic [2:0] ST_REF   = 3'd3;
    localparam logic [2:0] ST_DRAWN = 3'd4;

    typedef enum logic [3:0] {
        MODE_ALLOC   = 4'd0,
        MODE_FREE    = 4'd1,
        MODE_STBY    = 4'd2,
        MODE_REF     = 4'd3,
        MODE_ENDREF  = 4'd4,
        MODE_ENDDRAW = 4'd5,
        MODE_KEYS    = 4'd6,
        MODE_LOCK    = 4'd7,
        MODE_HOLD    = 4'd8,
        MODE_TWO     = 4'd9,
        MODE_COUNT   = 4'd10,
        MODE_GOP     = 4'd11,
        MODE_TERM    = 4'd12
    } mode_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_READ  = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

endpackage

// File: hw/rtl/decoded_frame_pool_manager.sv
// Channel   Direction  Handshake          Payload
// command   in         start & !busy      mode, frame_index, keys, flag_value
// result    out        done (one cycle)   found .. terminated
// config    in         active_frames_we   active_frames_wdata
// A slot write or flag operation passes through the scan and done states before its result;
// allocate, hold, two and count also step through up to min(active_frames, MAX_FRAMES) slots,
// visiting each slot in a scan state and a read state (key memory read, compare).
// The next transfer can be accepted in the cycle after done.
// Reset clears slot status, locks and flags; keys are undefined until written.
// busy is high from acceptance through the done cycle; results cannot stall.
module decoded_frame_pool_manager #(
    parameter int TREF_BITS  = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic        active_frames_we,
    input  logic [4:0]  active_frames_wdata,
    input  logic [3:0]  mode,
    input  logic [3:0]  frame_index,
    input  logic [15:0] gop_number,
    input  logic [15:0] order_key_major,
    input  logic [15:0] order_key_minor,
    input  logic [9:0]  temporal_ref,
    input  logic        flag_value,
    output logic        found,
    output logic [3:0]  first_index,
    output logic        second_found,
    output logic [3:0]  second_index,
    output logic        last_frame,
    output logic [4:0]  ready_count,
    output logic        stream_exhausted,
    output logic        terminated
);
    import dfpm_pkg::*;

    localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int KW = 48 + TREF_BITS;
    localparam logic [TREF_BITS-1:0] TREF_HALF = {1'b1, {(TREF_BITS-1){1'b0}}};

    state_t state_reg, state_next;
    logic [2:0] status_reg [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] lock_reg;
    logic [KW-1:0] key_mem [MAX_FRAMES];
    logic [KW-1:0] rd_key_reg;
    logic [KW-1:0] best1_reg, best2_reg;
    logic [4:0] active_reg;
    logic done_reg, term_reg, gop_reg;
    logic [3:0] mode_reg;
    logic [IW:0] idx_reg;
    logic [IW-1:0] f1_reg, f2_reg;
    logic v1_reg, v2_reg, alloc_hit_reg;
    logic [CW-1:0] n_reg;
    logic found_reg, found2_reg, last_reg, exh_reg;
    logic [3:0] first_reg, second_reg;
    logic [4:0] count_reg;

    logic [CW:0] lim;
    logic slot_ok;
    logic [IW-1:0] cur;
    logic waiting;
    logic accept;

    assign lim = (active_reg > 5'(MAX_FRAMES)) ? (CW+1)'(MAX_FRAMES) : (CW+1)'(active_reg);
    assign slot_ok = 32'(frame_index) < MAX_FRAMES;
    assign cur = idx_reg[IW-1:0];
    assign waiting = (status_reg[cur] == ST_STBY) || (status_reg[cur] == ST_REF);
    assign accept = start && !busy;

    function automatic logic earlier(input logic [KW-1:0] a, input logic [KW-1:0] b);
        logic [TREF_BITS-1:0] ta, tb, dab, dba;
        ta = a[TREF_BITS-1:0];
        tb = b[TREF_BITS-1:0];
        dab = ta - tb;
        dba = tb - ta;
        if (a[KW-1:TREF_BITS] != b[KW-1:TREF_BITS])
            return a[KW-1:TREF_BITS] < b[KW-1:TREF_BITS];
        if (ta > tb && dab > TREF_HALF) return 1'b1;
        if (tb > ta && dba > TREF_HALF) return 1'b0;
        return ta < tb;
    endfunction

    logic e1, e2;
    assign e1 = !v1_reg || earlier(rd_key_reg, best1_reg);
    assign e2 = !v2_reg || earlier(rd_key_reg, best2_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_SCAN;
            S_SCAN:
            begin
                if (mode_reg == MODE_ALLOC || mode_reg == MODE_HOLD || mode_reg == MODE_TWO
                    || mode_reg == MODE_COUNT)
                begin
                    if ((CW+1)'(idx_reg) >= lim || alloc_hit_reg) state_next = S_DONE;
                    else state_next = S_READ;
                end
                else state_next = S_DONE;
            end
            S_READ: state_next = S_SCAN;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && accept && mode == MODE_KEYS && slot_ok)
            key_mem[frame_index[IW-1:0]] <= {gop_number, order_key_major, order_key_minor,
                                             TREF_BITS'(temporal_ref)};
        rd_key_reg <= key_mem[cur];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < MAX_FRAMES; i++) status_reg[i] <= ST_FREE;
            lock_reg <= '0;
            active_reg <= 5'd16;
            term_reg <= 1'b0;
            gop_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= MODE_TERM;
            idx_reg <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            alloc_hit_reg <= 1'b0;
            n_reg <= '0;
            f1_reg <= '0;
            f2_reg <= '0;
            best1_reg <= '0;
            best2_reg <= '0;
            found_reg <= 1'b0;
            found2_reg <= 1'b0;
            first_reg <= '0;
            second_reg <= '0;
            last_reg <= 1'b0;
            count_reg <= '0;
            exh_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= 1'b0;
            if (active_frames_we) active_reg <= active_frames_wdata;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        mode_reg <= mode;
                        idx_reg <= '0;
                        v1_reg <= 1'b0;
                        v2_reg <= 1'b0;
                        alloc_hit_reg <= 1'b0;
                        n_reg <= '0;
                        f1_reg <= '0;
                        f2_reg <= '0;
                        if (slot_ok)
                        begin
                            case (mode)
                                MODE_FREE: status_reg[frame_index[IW-1:0]] <= ST_FREE;
                                MODE_STBY: status_reg[frame_index[IW-1:0]] <= ST_STBY;
                                MODE_REF:  status_reg[frame_index[IW-1:0]] <= ST_REF;
                                MODE_ENDREF:
                                    status_reg[frame_index[IW-1:0]] <=
                                        (status_reg[frame_index[IW-1:0]] == ST_REF)
                                        ? ST_STBY : ST_FREE;
                                MODE_ENDDRAW:
                                    status_reg[frame_index[IW-1:0]] <=
                                        (status_reg[frame_index[IW-1:0]] == ST_REF)
                                        ? ST_DRAWN : ST_FREE;
                                MODE_LOCK: lock_reg[frame_index[IW-1:0]] <= flag_value;
                                default: ;
                            endcase
                        end
                        if (mode == MODE_GOP) gop_reg <= flag_value;
                        if (mode == MODE_TERM) term_reg <= 1'b1;
                    end
                end
                S_SCAN:
                begin
                    if (mode_reg == MODE_ALLOC && (CW+1)'(idx_reg) < lim && !alloc_hit_reg)
                    begin
                        if (status_reg[cur] == ST_FREE && !lock_reg[cur])
                        begin
                            status_reg[cur] <= ST_ALLOC;
                            alloc_hit_reg <= 1'b1;
                            f1_reg <= cur;
                        end
                        else idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_READ:
                begin
                    if (mode_reg != MODE_ALLOC)
                    begin
                        if (waiting)
                        begin
                            n_reg <= n_reg + 1'b1;
                            if (e1)
                            begin
                                f2_reg <= f1_reg;
                                v2_reg <= v1_reg;
                                best2_reg <= best1_reg;
                                f1_reg <= cur;
                                v1_reg <= 1'b1;
                                best1_reg <= rd_key_reg;
                            end
                            else if (e2)
                            begin
                                f2_reg <= cur;
                                v2_reg <= 1'b1;
                                best2_reg <= rd_key_reg;
                            end
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    done_reg <= 1'b1;
                    found_reg <= 1'b0;
                    found2_reg <= 1'b0;
                    first_reg <= '0;
                    second_reg <= '0;
                    last_reg <= 1'b0;
                    count_reg <= '0;
                    exh_reg <= 1'b0;
                    case (mode_reg)
                        MODE_ALLOC:
                        begin
                            found_reg <= alloc_hit_reg;
                            first_reg <= alloc_hit_reg ? 4'(f1_reg) : 4'd0;
                        end
                        MODE_HOLD:
                        begin
                            if (v1_reg && !(n_reg == CW'(1) && !term_reg && !gop_reg))
                            begin
                                found_reg <= 1'b1;
                                first_reg <= 4'(f1_reg);
                            end
                            last_reg <= (n_reg == CW'(1)) && term_reg;
                        end
                        MODE_TWO:
                        begin
                            if (term_reg ? (n_reg != '0) : (n_reg > CW'(1)))
                            begin
                                found_reg <= v1_reg;
                                first_reg <= v1_reg ? 4'(f1_reg) : 4'd0;
                                if (term_reg ? (n_reg > CW'(1)) : (n_reg > CW'(2)))
                                begin
                                    found2_reg <= v2_reg;
                                    second_reg <= v2_reg ? 4'(f2_reg) : 4'd0;
                                end
                            end
                        end
                        MODE_COUNT:
                        begin
                            count_reg <= 5'(n_reg);
                            exh_reg <= term_reg && (n_reg == '0);
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE) || done_reg;
    assign done = done_reg;
    assign found = found_reg;
    assign first_index = first_reg;
    assign second_found = found2_reg;
    assign second_index = second_reg;
    assign last_frame = last_reg;
    assign ready_count = count_reg;
    assign stream_exhausted = exh_reg;
    assign terminated = term_reg;

`ifndef NO_ASSERTIONS
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("done without busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done longer than one cycle");
    a_exh_count: assert property (@(posedge clk) disable iff (!rst_n)
        stream_exhausted |-> (ready_count == 5'd0 && terminated))
        else $error("exhausted with frames");
    a_second_first: assert property (@(posedge clk) disable iff (!rst_n)
        second_found |-> (found && second_index != first_index))
        else $error("second without distinct first");
`endif

endmodule

// File: sim/decoded_frame_pool_manager_tb.sv
`timescale 1ns / 1ps

module decoded_frame_pool_manager_tb;
    import dfpm_pkg::*;

    typedef struct packed {
        logic       found;
        logic [3:0] first_index;
        logic       second_found;
        logic [3:0] second_index;
        logic       last_frame;
        logic [4:0] ready_count;
        logic       stream_exhausted;
        logic       terminated;
    } pool_answer_t;

    localparam int SLOTS = 16;
    localparam int TREF_WRAP = 512;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        done;
    logic        active_frames_we;
    logic [4:0]  active_frames_wdata;
    logic [3:0]  mode;
    logic [3:0]  frame_index;
    logic [15:0] gop_number;
    logic [15:0] order_key_major;
    logic [15:0] order_key_minor;
    logic [9:0]  temporal_ref;
    logic        flag_value;
    logic        found;
    logic [3:0]  first_index;
    logic        second_found;
    logic [3:0]  second_index;
    logic        last_frame;
    logic [4:0]  ready_count;
    logic        stream_exhausted;
    logic        terminated;

    logic [2:0]  pool_status [SLOTS];
    logic        pool_lock [SLOTS];
    logic [15:0] pool_gop [SLOTS];
    logic [15:0] pool_major [SLOTS];
    logic [15:0] pool_minor [SLOTS];
    logic [9:0]  pool_tref [SLOTS];
    logic        pool_done;
    logic        pool_gop_active;
    logic [4:0]  pool_active;

    pool_answer_t answers_due [$];
    int errors;
    int idle_pct;

    decoded_frame_pool_manager dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .done(done),
        .active_frames_we(active_frames_we),
        .active_frames_wdata(active_frames_wdata),
        .mode(mode),
        .frame_index(frame_index),
        .gop_number(gop_number),
        .order_key_major(order_key_major),
        .order_key_minor(order_key_minor),
        .temporal_ref(temporal_ref),
        .flag_value(flag_value),
        .found(found),
        .first_index(first_index),
        .second_found(second_found),
        .second_index(second_index),
        .last_frame(last_frame),
        .ready_count(ready_count),
        .stream_exhausted(stream_exhausted),
        .terminated(terminated)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic bit shown_before(int a, int b, bit b_valid);
        int ta;
        int tb;
        if (!b_valid)
            return 1'b1;
        if (pool_gop[a] != pool_gop[b])
            return pool_gop[a] < pool_gop[b];
        if (pool_major[a] != pool_major[b])
            return pool_major[a] < pool_major[b];
        if (pool_minor[a] != pool_minor[b])
            return pool_minor[a] < pool_minor[b];
        ta = pool_tref[a];
        tb = pool_tref[b];
        if (ta - tb > TREF_WRAP)
            return 1'b1;
        if (tb - ta > TREF_WRAP)
            return 1'b0;
        return ta < tb;
    endfunction

    function automatic bit is_waiting(int i);
        return pool_status[i] == ST_STBY || pool_status[i] == ST_REF;
    endfunction

    function automatic pool_answer_t apply_pool_op(logic [3:0] op, logic [3:0] slot,
                                                   logic [15:0] g, logic [15:0] kmaj,
                                                   logic [15:0] kmin, logic [9:0] tr,
                                                   logic flag);
        pool_answer_t r;
        int lim;
        int n;
        int f1;
        int f2;
        bit v1;
        bit v2;
        r = '0;
        lim = (pool_active > SLOTS) ? SLOTS : pool_active;
        n = 0;
        f1 = 0;
        f2 = 0;
        v1 = 0;
        v2 = 0;
        case (op)
            MODE_ALLOC:
                for (int i = 0; i < lim; i++)
                begin
                    if (!r.found && pool_status[i] == ST_FREE && !pool_lock[i])
                    begin
                        pool_status[i] = ST_ALLOC;
                        r.found = 1'b1;
                        r.first_index = 4'(i);
                    end
                end
            MODE_FREE: pool_status[slot] = ST_FREE;
            MODE_STBY: pool_status[slot] = ST_STBY;
            MODE_REF: pool_status[slot] = ST_REF;
            MODE_ENDREF: pool_status[slot] = (pool_status[slot] == ST_REF) ? ST_STBY : ST_FREE;
            MODE_ENDDRAW: pool_status[slot] = (pool_status[slot] == ST_REF) ? ST_DRAWN : ST_FREE;
            MODE_KEYS:
            begin
                pool_gop[slot] = g;
                pool_major[slot] = kmaj;
                pool_minor[slot] = kmin;
                pool_tref[slot] = tr;
            end
            MODE_LOCK: pool_lock[slot] = flag;
            MODE_HOLD:
            begin
                for (int i = 0; i < lim; i++)
                begin
                    if (is_waiting(i))
                    begin
                        n++;
                        if (shown_before(i, f1, v1))
                        begin
                            f1 = i;
                            v1 = 1;
                        end
                    end
                end
                if (n == 1)
                begin
                    if (pool_done)
                        r.last_frame = 1'b1;
                    else if (!pool_gop_active)
                        v1 = 0;
                end
                if (v1)
                begin
                    r.found = 1'b1;
                    r.first_index = 4'(f1);
                end
            end
            MODE_TWO:
            begin
                for (int i = 0; i < lim; i++)
                begin
                    if (is_waiting(i))
                    begin
                        n++;
                        if (shown_before(i, f1, v1))
                        begin
                            f2 = f1;
                            v2 = v1;
                            f1 = i;
                            v1 = 1;
                        end
                        else if (shown_before(i, f2, v2))
                        begin
                            f2 = i;
                            v2 = 1;
                        end
                    end
                end
                if (!pool_done && n > 0)
                    n--;
                if (n == 0)
                begin
                    v1 = 0;
                    v2 = 0;
                end
                else if (n == 1)
                    v2 = 0;
                if (v1)
                begin
                    r.found = 1'b1;
                    r.first_index = 4'(f1);
                end
                if (v2)
                begin
                    r.second_found = 1'b1;
                    r.second_index = 4'(f2);
                end
            end
            MODE_COUNT:
            begin
                for (int i = 0; i < lim; i++)
                    if (is_waiting(i))
                        n++;
                r.stream_exhausted = pool_done && n == 0;
                r.ready_count = 5'(n);
            end
            MODE_GOP: pool_gop_active = flag;
            MODE_TERM: pool_done = 1'b1;
            default: ;
        endcase
        r.terminated = pool_done;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        pool_answer_t want;
        if (rst_n && done)
        begin
            if (answers_due.size() == 0)
                report_mismatch("unexpected result transfer, count", 1, 0);
            else
            begin
                want = answers_due.pop_front();
                if (found !== want.found)
                    report_mismatch("found", found, want.found);
                if (first_index !== want.first_index)
                    report_mismatch("first_index", first_index, want.first_index);
                if (second_found !== want.second_found)
                    report_mismatch("second_found", second_found, want.second_found);
                if (second_index !== want.second_index)
                    report_mismatch("second_index", second_index, want.second_index);
                if (last_frame !== want.last_frame)
                    report_mismatch("last_frame", last_frame, want.last_frame);
                if (ready_count !== want.ready_count)
                    report_mismatch("ready_count", ready_count, want.ready_count);
                if (stream_exhausted !== want.stream_exhausted)
                    report_mismatch("stream_exhausted", stream_exhausted,
                                    want.stream_exhausted);
                if (terminated !== want.terminated)
                    report_mismatch("terminated", terminated, want.terminated);
            end
        end
    end

    task automatic send_op(logic [3:0] op, logic [3:0] slot, logic [15:0] g,
                           logic [15:0] kmaj, logic [15:0] kmin, logic [9:0] tr,
                           logic flag);
        mode <= op;
        frame_index <= slot;
        gop_number <= g;
        order_key_major <= kmaj;
        order_key_minor <= kmin;
        temporal_ref <= tr;
        flag_value <= flag;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        answers_due.push_back(apply_pool_op(op, slot, g, kmaj, kmin, tr, flag));
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic send_simple(logic [3:0] op, logic [3:0] slot, logic flag);
        send_op(op, slot, 16'($urandom), 16'($urandom), 16'($urandom), 10'($urandom), flag);
    endtask

    // hold until every result has arrived and the block is idle
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (answers_due.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_active(logic [4:0] value);
        drain();
        active_frames_we <= 1'b1;
        active_frames_wdata <= value;
        @(posedge clk);
        active_frames_we <= 1'b0;
        pool_active = value;
    endtask

    task automatic send_random_op();
        logic [3:0] op;
        int pick;
        pick = $urandom_range(99);
        if (pick < 12)
            op = MODE_ALLOC;
        else if (pick < 50)
            op = 4'($urandom_range(MODE_FREE, MODE_LOCK));
        else if (pick < 90)
            op = 4'($urandom_range(MODE_HOLD, MODE_COUNT));
        else if (pick < 96)
            op = MODE_GOP;
        else
            op = 4'($urandom_range(13, 15));
        if (op == MODE_KEYS && $urandom_range(1))
            send_op(op, 4'($urandom), 16'($urandom_range(3)), 16'($urandom_range(3)),
                    16'($urandom_range(3)), 10'($urandom), 1'($urandom));
        else
            send_op(op, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    10'($urandom), 1'($urandom));
    endtask

    task automatic test_keys();
        // every slot gets keys before any can wait; the first few hit wrap edges
        send_op(MODE_KEYS, 0, 16'h0000, 16'h0000, 16'h0000, 10'd0, 1'b0);
        send_op(MODE_KEYS, 1, 16'h0000, 16'h0000, 16'h0000, 10'd1023, 1'b1);
        send_op(MODE_KEYS, 2, 16'h0000, 16'h0000, 16'h0000, 10'd512, 1'b0);
        send_op(MODE_KEYS, 3, 16'h0000, 16'h0000, 16'h0000, 10'd511, 1'b0);
        send_op(MODE_KEYS, 4, 16'hffff, 16'hffff, 16'hffff, 10'd513, 1'b0);
        send_op(MODE_KEYS, 5, 16'h0000, 16'hffff, 16'h0000, 10'd0, 1'b0);
        for (int i = 6; i < SLOTS; i++)
            send_op(MODE_KEYS, 4'(i), 16'($urandom_range(1)), 16'($urandom_range(1)),
                    16'($urandom), 10'($urandom), 1'b0);
    endtask

    task automatic test_slot_ops();
        send_simple(MODE_STBY, 0, 0);
        send_simple(MODE_HOLD, 0, 0);
        send_simple(MODE_GOP, 0, 1);
        send_simple(MODE_HOLD, 0, 0);
        send_simple(MODE_REF, 1, 0);
        send_simple(MODE_REF, 2, 0);
        send_simple(MODE_STBY, 3, 0);
        send_simple(MODE_HOLD, 0, 0);
        send_simple(MODE_TWO, 0, 0);
        send_simple(MODE_COUNT, 0, 0);
        send_simple(MODE_ENDREF, 1, 0);
        send_simple(MODE_ENDDRAW, 2, 0);
        send_simple(MODE_ENDREF, 3, 0);
        send_simple(MODE_ENDDRAW, 0, 0);
        send_simple(MODE_LOCK, 0, 1);
        send_simple(MODE_ALLOC, 0, 0);
        send_simple(MODE_LOCK, 0, 0);
        send_simple(MODE_ALLOC, 0, 0);
        send_simple(13, 0, 0);
        send_simple(15, 15, 1);
        send_simple(MODE_FREE, 15, 0);
    endtask

    task automatic test_random_phases();
        logic [4:0] settings [5] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd9};
        int pcts [4] = '{0, 71, 0, 16};
        for (int p = 0; p < 5; p++)
        begin
            write_active(p == 4 ? 5'($urandom_range(2, 16)) : settings[p]);
            idle_pct = pcts[p % 4];
            repeat (p < 2 ? 20 : 10)
                send_op(MODE_FREE, 4'($urandom), 0, 0, 0, 0, 0);
            repeat (p < 2 ? 60 : 50)
                send_random_op();
        end
    endtask

    task automatic test_terminate();
        write_active(5'd16);
        idle_pct = 16;
        send_simple(MODE_COUNT, 0, 0);
        send_simple(MODE_TERM, 0, 0);
        repeat (40)
            send_random_op();
        for (int i = 0; i < SLOTS; i++)
            send_simple(MODE_FREE, 4'(i), 0);
        send_simple(MODE_COUNT, 0, 0);
        send_simple(MODE_STBY, 7, 0);
        send_simple(MODE_HOLD, 0, 0);
        send_simple(MODE_TWO, 0, 0);
    endtask

    initial
    begin
        errors = 0;
        idle_pct = 0;
        pool_done = 0;
        pool_gop_active = 0;
        pool_active = 5'd16;
        for (int i = 0; i < SLOTS; i++)
        begin
            pool_status[i] = ST_FREE;
            pool_lock[i] = 0;
            pool_gop[i] = 0;
            pool_major[i] = 0;
            pool_minor[i] = 0;
            pool_tref[i] = 0;
        end
        rst_n <= 1'b0;
        start <= 1'b0;
        active_frames_we <= 1'b0;
        active_frames_wdata <= '0;
        mode <= MODE_ALLOC;
        frame_index <= '0;
        gop_number <= '0;
        order_key_major <= '0;
        order_key_minor <= '0;
        temporal_ref <= '0;
        flag_value <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_keys();
        test_slot_ops();
        test_random_phases();
        test_terminate();
        drain();
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/dfpm_pkg.sv
hw/rtl/decoded_frame_pool_manager.sv
sim/decoded_frame_pool_manager_tb.sv
